// File: hw/rtl/ple_pkg.sv
// types and constants shared by the positional list engine
// no dependencies
package ple_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ADDR_W   = 6;
  localparam int unsigned CNT_W    = 7;
  localparam int unsigned DATA_W   = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_READ   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef struct packed {
    cmd_e                     command;
    logic signed [DATA_W-1:0] value;
    logic [CNT_W-1:0]         position;
  } in_t;

  typedef struct packed {
    status_e                  status;
    logic                     found;
    logic signed [DATA_W-1:0] read_value;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
  } out_t;

endpackage

// File: hw/rtl/positional_list_engine.sv
// positional list engine: ordered list of signed words held in one memory
// depends on ple_pkg
//
// usage
//   commands arrive on the in_* valid/ready channel, one transfer per command
//   (insert, remove, search, read); every command gives exactly one result
//   transfer on the out_* channel with status, found flag, read value, the
//   length after the command and an empty flag
//   the entries live in one 64 x 32 synchronous memory (one read port, one
//   write port, registered read data); inserts and removes move the later
//   entries one place per cycle through that memory, a search scans them
// steps per command, paced by the single read port, each ending in S_DONE
//   insert that shifts:   read the last entry, then S_INS, then S_PUT
//   remove that shifts:   read the entry after position, then S_REM
//   search:               S_SRCH over every entry (skipped on an empty list)
//   read:                 S_RD
//   errors, full, append, remove of the last entry: straight to S_DONE
//   the result appears in the same cycle as the block becomes ready again
// reset clears the length to zero and drops any pending result; memory
//   contents are left as they are, only entries below the length are read
// a stalled receiver holds the result in the output register; the block
//   finishes the next command and then waits until that register is free
module positional_list_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ple_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ple_pkg::out_t out_data_o
);

  // one-hot sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INS  = 7'b0000010,  // moving entries up, highest first
    S_PUT  = 7'b0000100,  // writing the new value into its gap
    S_REM  = 7'b0001000,  // moving entries down, lowest first
    S_SRCH = 7'b0010000,  // scanning valid entries
    S_RD   = 7'b0100000,  // read data returning
    S_DONE = 7'b1000000   // result waiting for the output register
  } state_e;

  state_e state_q, state_d;

  logic [ple_pkg::CNT_W-1:0]         cnt_q, cnt_d;
  logic [ple_pkg::ADDR_W-1:0]        ptr_q, ptr_d;
  logic [ple_pkg::CNT_W-1:0]         pos_q, pos_d;
  logic signed [ple_pkg::DATA_W-1:0] val_q, val_d;

  // result under construction
  ple_pkg::status_e                  status_q, status_d;
  logic                              found_q, found_d;
  logic signed [ple_pkg::DATA_W-1:0] rv_q, rv_d;

  // output register
  logic          out_valid_q, out_valid_d;
  ple_pkg::out_t out_q, out_d;

  // memory port signals
  logic [ple_pkg::DATA_W-1:0] mem_q [ple_pkg::CAPACITY];
  logic                       mem_we, mem_re;
  logic [ple_pkg::ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [ple_pkg::DATA_W-1:0] mem_wdata, mem_rdata_q;

  logic [ple_pkg::CNT_W-1:0]  cnt_m1;
  logic [ple_pkg::CNT_W-1:0]  in_pos_p1;
  logic [ple_pkg::ADDR_W-1:0] last_addr;

  assign cnt_m1    = cnt_q - ple_pkg::CNT_W'(1);
  assign in_pos_p1 = in_data_i.position + ple_pkg::CNT_W'(1);
  assign last_addr = cnt_m1[ple_pkg::ADDR_W-1:0];

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    val_d       = val_q;
    status_d    = status_q;
    found_d     = found_q;
    rv_d        = rv_q;
    out_d       = out_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    mem_we      = 1'b0;
    mem_waddr   = ptr_q;
    mem_wdata   = mem_rdata_q;
    mem_re      = 1'b0;
    mem_raddr   = ptr_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          val_d    = in_data_i.value;
          pos_d    = in_data_i.position;
          status_d = ple_pkg::ST_OK;
          found_d  = 1'b0;
          rv_d     = '0;
          state_d  = S_DONE;
          case (in_data_i.command)
            ple_pkg::CMD_INSERT: begin
              if (in_data_i.position > cnt_q) begin
                status_d = ple_pkg::ST_BAD_POS;
              end else if (cnt_q == ple_pkg::CNT_W'(ple_pkg::CAPACITY)) begin
                status_d = ple_pkg::ST_FULL;
              end else if (in_data_i.position == cnt_q) begin
                // append: nothing to move
                mem_we    = 1'b1;
                mem_waddr = in_data_i.position[ple_pkg::ADDR_W-1:0];
                mem_wdata = in_data_i.value;
                cnt_d     = cnt_q + ple_pkg::CNT_W'(1);
              end else begin
                mem_re    = 1'b1;
                mem_raddr = last_addr;
                ptr_d     = last_addr;
                state_d   = S_INS;
              end
            end
            ple_pkg::CMD_REMOVE: begin
              if (in_data_i.position >= cnt_q) begin
                status_d = ple_pkg::ST_BAD_POS;
              end else if (in_data_i.position == cnt_m1) begin
                cnt_d = cnt_m1;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_pos_p1[ple_pkg::ADDR_W-1:0];
                ptr_d     = in_pos_p1[ple_pkg::ADDR_W-1:0];
                state_d   = S_REM;
              end
            end
            ple_pkg::CMD_SEARCH: begin
              if (cnt_q != '0) begin
                mem_re    = 1'b1;
                mem_raddr = '0;
                ptr_d     = '0;
                state_d   = S_SRCH;
              end
            end
            ple_pkg::CMD_READ: begin
              if (in_data_i.position >= cnt_q) begin
                status_d = ple_pkg::ST_BAD_POS;
              end else begin
                mem_re    = 1'b1;
                mem_raddr = in_data_i.position[ple_pkg::ADDR_W-1:0];
                state_d   = S_RD;
              end
            end
            default: begin
              status_d = ple_pkg::ST_OK;
            end
          endcase
        end
      end

      S_INS: begin
        // entry at ptr moves to ptr + 1
        mem_we    = 1'b1;
        mem_waddr = ptr_q + ple_pkg::ADDR_W'(1);
        mem_wdata = mem_rdata_q;
        if ({1'b0, ptr_q} == pos_q) begin
          state_d = S_PUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q - ple_pkg::ADDR_W'(1);
          ptr_d     = ptr_q - ple_pkg::ADDR_W'(1);
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[ple_pkg::ADDR_W-1:0];
        mem_wdata = val_q;
        cnt_d     = cnt_q + ple_pkg::CNT_W'(1);
        state_d   = S_DONE;
      end

      S_REM: begin
        // entry at ptr moves to ptr - 1
        mem_we    = 1'b1;
        mem_waddr = ptr_q - ple_pkg::ADDR_W'(1);
        mem_wdata = mem_rdata_q;
        if (ptr_q == last_addr) begin
          cnt_d   = cnt_m1;
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + ple_pkg::ADDR_W'(1);
          ptr_d     = ptr_q + ple_pkg::ADDR_W'(1);
        end
      end

      S_SRCH: begin
        found_d = found_q | (mem_rdata_q == val_q);
        if (ptr_q == last_addr) begin
          state_d = S_DONE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = ptr_q + ple_pkg::ADDR_W'(1);
          ptr_d     = ptr_q + ple_pkg::ADDR_W'(1);
        end
      end

      S_RD: begin
        rv_d    = mem_rdata_q;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.status     = status_q;
          out_d.found      = found_q;
          out_d.read_value = rv_q;
          out_d.count      = cnt_q;
          out_d.empty_res  = (cnt_q == '0);
          out_valid_d      = 1'b1;
          state_d          = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    status_q <= status_d;
    found_q  <= found_d;
    rv_q     <= rv_d;
    out_q    <= out_d;
  end

  // entry memory; read and write addresses never coincide in one cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

endmodule
